// ===== rtl/plews_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// plews_pkg
// Shared types and constants of the power logger energy and window
// statistics block.
// ----------------------------------------------------------------------------
package plews_pkg;

    localparam int SAMPLE_DEPTH = 1024;
    localparam int ADDR_W       = $clog2(SAMPLE_DEPTH);
    localparam int CNT_W        = ADDR_W + 1;
    localparam int SUM_W        = 24 + CNT_W;
    localparam int DVD_W        = 74;
    localparam int DVS_W        = 20;
    localparam int CFG_IDX_W    = 4;
    localparam int CFG_DATA_W   = 32;

    // request and result codes
    localparam logic [1:0] REQ_SAMPLE = 2'd0;
    localparam logic [1:0] REQ_RESET  = 2'd1;
    localparam logic [1:0] REQ_QUERY  = 2'd2;
    localparam logic [1:0] REQ_CLEAR  = 2'd3;

    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_RESET  = 2'd1;
    localparam logic [1:0] KIND_QUERY  = 2'd2;
    localparam logic [1:0] KIND_CLEAR  = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_GAP  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_MEAN = 4'd1;

    // statistic indexes
    localparam logic [3:0] STAT_COUNT  = 4'd0;
    localparam logic [3:0] STAT_DUR    = 4'd1;
    localparam logic [3:0] STAT_MEAN_V = 4'd2;
    localparam logic [3:0] STAT_MEAN_I = 4'd3;
    localparam logic [3:0] STAT_MEAN_P = 4'd4;
    localparam logic [3:0] STAT_PEAK_V = 4'd5;
    localparam logic [3:0] STAT_PEAK_I = 4'd6;
    localparam logic [3:0] STAT_PEAK_P = 4'd7;
    localparam logic [3:0] STAT_MIN_V  = 4'd8;
    localparam logic [3:0] STAT_MIN_I  = 4'd9;
    localparam logic [3:0] STAT_MIN_P  = 4'd10;
    localparam logic [3:0] STAT_ENERGY = 4'd11;
    localparam logic [3:0] STAT_CHARGE = 4'd12;

    // charge quotient at or above this saturates
    localparam logic [DVD_W-1:0] CHARGE_SAT_LIM = 74'd18446744073709551000;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] time_ms;
        logic [19:0] voltage_mv;
        logic [19:0] current_ma;
        logic [23:0] power_mw;
        logic [2:0]  mode_flags;
        logic [3:0]  alarm_flags;
        logic [31:0] range_start_ms;
        logic [31:0] range_end_ms;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [3:0]  stat_index;
        logic [63:0] value;
        logic        last;
        logic        new_alarm;
        logic        flags_changed;
        logic [3:0]  alarm_state;
    } out_item_t;

    typedef struct packed {
        logic [31:0] time_ms;
        logic [19:0] voltage_mv;
        logic [19:0] current_ma;
        logic [23:0] power_mw;
        logic [63:0] energy;
    } entry_t;

endpackage
`default_nettype wire

// ===== rtl/plews_store.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// plews_store
// Sample ring memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module plews_store
(
    input  wire logic                        clk,
    input  wire logic                        wr_en,
    input  wire logic [plews_pkg::ADDR_W-1:0] wr_addr,
    input  wire plews_pkg::entry_t           wr_data,
    input  wire logic                        rd_en,
    input  wire logic [plews_pkg::ADDR_W-1:0] rd_addr,
    output plews_pkg::entry_t                rd_data
);

    plews_pkg::entry_t mem [plews_pkg::SAMPLE_DEPTH];
    plews_pkg::entry_t rd_data_reg;

    // write the new record
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read one record a cycle
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// ===== rtl/plews_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// plews_div
// Restoring divider, one quotient bit a cycle, shared by means and charge.
// ----------------------------------------------------------------------------
module plews_div
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [plews_pkg::DVD_W-1:0]  dividend,
    input  wire logic [plews_pkg::DVS_W-1:0]  divisor,
    output logic                              done,
    output logic [plews_pkg::DVD_W-1:0]       quotient
);

    localparam int STEP_W = $clog2(plews_pkg::DVD_W);

    logic [plews_pkg::DVD_W-1:0] quo_reg;
    logic [plews_pkg::DVS_W-1:0] rem_reg;
    logic [plews_pkg::DVS_W-1:0] rem_next;
    logic [plews_pkg::DVS_W-1:0] dvs_reg;
    logic [STEP_W-1:0]           step_reg;
    logic                        busy_reg;
    logic                        done_reg;
    logic [plews_pkg::DVS_W:0]   trial;
    logic                        qbit;

    // trial subtract of the shifted remainder
    always_comb
    begin
        trial = {rem_reg, quo_reg[plews_pkg::DVD_W-1]};
        qbit  = (trial >= {1'b0, dvs_reg});
        if (qbit)
        begin
            rem_next = plews_pkg::DVS_W'(trial - {1'b0, dvs_reg});
        end
        else
        begin
            rem_next = trial[plews_pkg::DVS_W-1:0];
        end
    end

    // sequence control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(plews_pkg::DVD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // shift quotient bits in
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[plews_pkg::DVD_W-2:0], qbit};
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

// ===== rtl/power_logger_energy_window_stats_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// power_logger_energy_window_stats_core
// Sample logger with trapezoidal energy integration and window statistics.
// ----------------------------------------------------------------------------
// One request is handled at a time. A sample passes through multiply, saturating
// add and ring write, then result load. Reset and clear requests go straight to
// result load. A range query reads the ring one record a cycle through the single
// memory read port, then, when the window holds records, runs three divisions on
// the shared bit-serial divider for the means and a fourth for the charge when
// the mean voltage gate is open, then emits its statistics in index order. No
// clearing pass is needed after reset: the fill count bounds every read.
module power_logger_energy_window_stats_core
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire plews_pkg::in_item_t              in_data,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output plews_pkg::out_item_t                  out_data,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [plews_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [plews_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_SMUL   = 4'd1;
    localparam logic [3:0] ST_SADD   = 4'd2;
    localparam logic [3:0] ST_WALK   = 4'd3;
    localparam logic [3:0] ST_DSTART = 4'd4;
    localparam logic [3:0] ST_DWAIT  = 4'd5;
    localparam logic [3:0] ST_CHG    = 4'd6;
    localparam logic [3:0] ST_CHG2   = 4'd7;
    localparam logic [3:0] ST_OUT    = 4'd8;

    localparam int AW = plews_pkg::ADDR_W;
    localparam int CW = plews_pkg::CNT_W;

    logic [3:0]  state_reg;
    logic [3:0]  state_next;

    // configuration
    logic [19:0] max_gap_reg;
    logic [19:0] min_mean_reg;

    // session state
    logic [AW-1:0] wp_reg;
    logic [CW-1:0] scnt_reg;
    logic [63:0]   total_reg;
    logic [63:0]   base_reg;
    logic [31:0]   prev_t_reg;
    logic [23:0]   prev_p_reg;
    logic          have_prev_reg;
    logic [6:0]    prev_flags_reg;

    // request being served
    plews_pkg::in_item_t req_reg;
    logic          new_alarm_reg;
    logic          changed_reg;
    logic [56:0]   inc_reg;
    logic [3:0]    out_idx_reg;

    // query walk
    logic [31:0]   lo_reg;
    logic [31:0]   hi_reg;
    logic [AW-1:0] pos_reg;
    logic [CW-1:0] n_reg;
    logic          rd_pend_reg;
    logic [CW-1:0] cnt_reg;
    logic [plews_pkg::SUM_W-1:0] sum_reg [3];
    logic [23:0]   peak_reg [3];
    logic [23:0]   min_reg [3];
    logic [23:0]   mean_reg [3];
    logic [63:0]   e_first_reg;
    logic [63:0]   e_last_reg;
    logic [63:0]   delta_reg;
    logic [plews_pkg::DVD_W-1:0] d1000_reg;
    logic [63:0]   charge_reg;
    logic [1:0]    div_sel_reg;

    // memory and divider
    logic              mem_wr_en;
    plews_pkg::entry_t mem_wr_data;
    logic              mem_rd_en;
    logic [AW-1:0]     mem_rd_addr;
    plews_pkg::entry_t mem_rd_data;
    logic              div_start;
    logic [plews_pkg::DVD_W-1:0] div_dvd;
    logic [plews_pkg::DVS_W-1:0] div_dvs;
    logic              div_done;
    logic [plews_pkg::DVD_W-1:0] div_quo;

    // output slot
    logic                 out_valid_reg;
    plews_pkg::out_item_t out_data_reg;
    logic                 slot_free;
    logic                 in_fire;
    logic                 cfg_fire;

    // datapath helpers
    logic [31:0]   dt;
    logic          gap_ok;
    logic [64:0]   e_sum;
    logic [63:0]   e_new;
    logic [23:0]   rx [3];
    logic          in_win;
    logic          last_q;
    logic [63:0]   stat_val;
    logic          gate;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    plews_store u_store
    (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (wp_reg),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    plews_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_quo)
    );

    // energy increment gate and saturating add
    always_comb
    begin
        dt     = req_reg.time_ms - prev_t_reg;
        gap_ok = have_prev_reg && (req_reg.time_ms > prev_t_reg)
                 && (dt < {12'd0, max_gap_reg});
        e_sum  = {1'b0, total_reg} + {8'd0, inc_reg};
        e_new  = e_sum[64] ? {64{1'b1}} : e_sum[63:0];
        mem_wr_en              = (state_reg == ST_SADD);
        mem_wr_data.time_ms    = req_reg.time_ms;
        mem_wr_data.voltage_mv = req_reg.voltage_mv;
        mem_wr_data.current_ma = req_reg.current_ma;
        mem_wr_data.power_mw   = req_reg.power_mw;
        mem_wr_data.energy     = e_new;
    end

    // walk reads and record selection
    always_comb
    begin
        mem_rd_en   = (state_reg == ST_WALK) && (n_reg < scnt_reg);
        mem_rd_addr = pos_reg + n_reg[AW-1:0];
        rx[0]  = {4'd0, mem_rd_data.voltage_mv};
        rx[1]  = {4'd0, mem_rd_data.current_ma};
        rx[2]  = mem_rd_data.power_mw;
        in_win = (mem_rd_data.time_ms >= lo_reg) && (mem_rd_data.time_ms <= hi_reg);
        gate   = (mean_reg[0] > {4'd0, min_mean_reg}) && (mean_reg[0] != 24'd0);
    end

    // divider operand selection
    always_comb
    begin
        div_start = (state_reg == ST_DSTART);
        case (div_sel_reg)
            2'd0:
            begin
                div_dvd = plews_pkg::DVD_W'(sum_reg[0]);
                div_dvs = plews_pkg::DVS_W'(cnt_reg);
            end
            2'd1:
            begin
                div_dvd = plews_pkg::DVD_W'(sum_reg[1]);
                div_dvs = plews_pkg::DVS_W'(cnt_reg);
            end
            2'd2:
            begin
                div_dvd = plews_pkg::DVD_W'(sum_reg[2]);
                div_dvs = plews_pkg::DVS_W'(cnt_reg);
            end
            default:
            begin
                div_dvd = d1000_reg;
                div_dvs = mean_reg[0][plews_pkg::DVS_W-1:0];
            end
        endcase
    end

    // result value for the current output index
    always_comb
    begin
        stat_val = 64'd0;
        last_q   = 1'b1;
        if (req_reg.req_type == plews_pkg::REQ_SAMPLE)
        begin
            stat_val = (total_reg >= base_reg) ? (total_reg - base_reg) : 64'd0;
        end
        else if (req_reg.req_type == plews_pkg::REQ_QUERY)
        begin
            last_q = (out_idx_reg == plews_pkg::STAT_CHARGE)
                     || ((out_idx_reg == plews_pkg::STAT_DUR) && (cnt_reg == '0));
            unique case (out_idx_reg)
                plews_pkg::STAT_COUNT:  stat_val = 64'(cnt_reg);
                plews_pkg::STAT_DUR:    stat_val = 64'(hi_reg - lo_reg);
                plews_pkg::STAT_MEAN_V: stat_val = 64'(mean_reg[0]);
                plews_pkg::STAT_MEAN_I: stat_val = 64'(mean_reg[1]);
                plews_pkg::STAT_MEAN_P: stat_val = 64'(mean_reg[2]);
                plews_pkg::STAT_PEAK_V: stat_val = 64'(peak_reg[0]);
                plews_pkg::STAT_PEAK_I: stat_val = 64'(peak_reg[1]);
                plews_pkg::STAT_PEAK_P: stat_val = 64'(peak_reg[2]);
                plews_pkg::STAT_MIN_V:  stat_val = 64'(min_reg[0]);
                plews_pkg::STAT_MIN_I:  stat_val = 64'(min_reg[1]);
                plews_pkg::STAT_MIN_P:  stat_val = 64'(min_reg[2]);
                plews_pkg::STAT_ENERGY: stat_val = delta_reg;
                plews_pkg::STAT_CHARGE: stat_val = charge_reg;
                default:                stat_val = 64'd0;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    case (in_data.req_type)
                        plews_pkg::REQ_SAMPLE: state_next = ST_SMUL;
                        plews_pkg::REQ_QUERY:  state_next = ST_WALK;
                        default:               state_next = ST_OUT;
                    endcase
                end
            end
            ST_SMUL:   state_next = ST_SADD;
            ST_SADD:   state_next = ST_OUT;
            ST_WALK:
            begin
                if ((n_reg == scnt_reg) && !rd_pend_reg)
                begin
                    state_next = (cnt_reg == '0) ? ST_OUT : ST_DSTART;
                end
            end
            ST_DSTART: state_next = ST_DWAIT;
            ST_DWAIT:
            begin
                if (div_done)
                begin
                    state_next = (div_sel_reg == 2'd2) ? ST_CHG
                               : (div_sel_reg == 2'd3) ? ST_OUT : ST_DSTART;
                end
            end
            ST_CHG:    state_next = ST_CHG2;
            ST_CHG2:   state_next = gate ? ST_DSTART : ST_OUT;
            ST_OUT:
            begin
                if (slot_free && last_q)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // control state, configuration and session state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            max_gap_reg    <= 20'd10000;
            min_mean_reg   <= 20'd10;
            wp_reg         <= '0;
            scnt_reg       <= '0;
            total_reg      <= 64'd0;
            base_reg       <= 64'd0;
            prev_t_reg     <= 32'd0;
            prev_p_reg     <= 24'd0;
            have_prev_reg  <= 1'b0;
            prev_flags_reg <= 7'd0;
            out_valid_reg  <= 1'b0;
            rd_pend_reg    <= 1'b0;
            n_reg          <= '0;
            out_idx_reg    <= 4'd0;
            div_sel_reg    <= 2'd0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_pend_reg <= mem_rd_en;
            if (mem_rd_en)
            begin
                n_reg <= n_reg + 1'b1;
            end

            // configuration writes
            if (cfg_fire && (cfg_index == plews_pkg::CFG_MAX_GAP))
            begin
                max_gap_reg <= cfg_data[19:0];
            end
            if (cfg_fire && (cfg_index == plews_pkg::CFG_MIN_MEAN))
            begin
                min_mean_reg <= cfg_data[19:0];
            end

            if (in_fire)
            begin
                n_reg       <= '0;
                out_idx_reg <= 4'd0;
                div_sel_reg <= 2'd0;
                case (in_data.req_type)
                    plews_pkg::REQ_SAMPLE:
                    begin
                        prev_flags_reg <= {in_data.alarm_flags, in_data.mode_flags};
                    end
                    plews_pkg::REQ_RESET:
                    begin
                        base_reg <= total_reg;
                    end
                    plews_pkg::REQ_CLEAR:
                    begin
                        wp_reg        <= '0;
                        scnt_reg      <= '0;
                        total_reg     <= 64'd0;
                        base_reg      <= 64'd0;
                        prev_t_reg    <= 32'd0;
                        prev_p_reg    <= 24'd0;
                        have_prev_reg <= 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
            end

            // commit the sample
            if (state_reg == ST_SADD)
            begin
                total_reg     <= e_new;
                have_prev_reg <= 1'b1;
                prev_t_reg    <= req_reg.time_ms;
                prev_p_reg    <= req_reg.power_mw;
                wp_reg        <= wp_reg + 1'b1;
                if (scnt_reg != CW'(plews_pkg::SAMPLE_DEPTH))
                begin
                    scnt_reg <= scnt_reg + 1'b1;
                end
            end

            // advance the divider sequence
            if ((state_reg == ST_DWAIT) && div_done)
            begin
                div_sel_reg <= div_sel_reg + 1'b1;
            end

            // output slot
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if ((state_reg == ST_OUT) && slot_free)
            begin
                out_valid_reg <= 1'b1;
                out_idx_reg   <= out_idx_reg + 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            req_reg       <= in_data;
            changed_reg   <= ({in_data.alarm_flags, in_data.mode_flags} != prev_flags_reg);
            new_alarm_reg <= ((in_data.alarm_flags & ~prev_flags_reg[6:3]) != 4'd0);
            lo_reg        <= (in_data.range_start_ms < in_data.range_end_ms)
                             ? in_data.range_start_ms : in_data.range_end_ms;
            hi_reg        <= (in_data.range_start_ms < in_data.range_end_ms)
                             ? in_data.range_end_ms : in_data.range_start_ms;
            pos_reg       <= wp_reg - scnt_reg[AW-1:0];
            cnt_reg       <= '0;
            e_first_reg   <= 64'd0;
            e_last_reg    <= 64'd0;
            charge_reg    <= 64'd0;
            for (int k = 0; k < 3; k++)
            begin
                sum_reg[k]  <= '0;
                peak_reg[k] <= 24'd0;
                min_reg[k]  <= 24'd0;
            end
        end

        // energy increment
        if (state_reg == ST_SMUL)
        begin
            inc_reg <= gap_ok
                       ? ({32'd0, {1'b0, req_reg.power_mw} + {1'b0, prev_p_reg}}
                          * {25'd0, dt})
                       : 57'd0;
        end

        // accumulate a record inside the window
        if (rd_pend_reg && in_win)
        begin
            for (int k = 0; k < 3; k++)
            begin
                sum_reg[k] <= sum_reg[k] + plews_pkg::SUM_W'(rx[k]);
                if ((cnt_reg == '0) || (rx[k] > peak_reg[k]))
                begin
                    peak_reg[k] <= rx[k];
                end
                if ((cnt_reg == '0) || (rx[k] < min_reg[k]))
                begin
                    min_reg[k] <= rx[k];
                end
            end
            if (cnt_reg == '0)
            begin
                e_first_reg <= mem_rd_data.energy;
            end
            e_last_reg <= mem_rd_data.energy;
            cnt_reg    <= cnt_reg + 1'b1;
        end

        // take the quotient
        if ((state_reg == ST_DWAIT) && div_done)
        begin
            if (div_sel_reg == 2'd3)
            begin
                charge_reg <= (div_quo >= plews_pkg::CHARGE_SAT_LIM)
                              ? {64{1'b1}} : div_quo[63:0];
            end
            else
            begin
                mean_reg[div_sel_reg] <= div_quo[23:0];
            end
        end

        // energy delta, then delta * 1000 as shifts
        if (state_reg == ST_CHG)
        begin
            delta_reg <= (e_last_reg >= e_first_reg) ? (e_last_reg - e_first_reg) : 64'd0;
        end
        if (state_reg == ST_CHG2)
        begin
            d1000_reg <= {delta_reg, 10'd0} - {6'd0, delta_reg, 4'd0}
                         - {7'd0, delta_reg, 3'd0};
        end

        // load a result
        if ((state_reg == ST_OUT) && slot_free)
        begin
            out_data_reg.result_kind   <= req_reg.req_type;
            out_data_reg.stat_index    <= (req_reg.req_type == plews_pkg::REQ_QUERY)
                                          ? out_idx_reg : plews_pkg::STAT_COUNT;
            out_data_reg.value         <= stat_val;
            out_data_reg.last          <= last_q;
            out_data_reg.new_alarm     <= (req_reg.req_type == plews_pkg::REQ_SAMPLE)
                                          && new_alarm_reg;
            out_data_reg.flags_changed <= (req_reg.req_type == plews_pkg::REQ_SAMPLE)
                                          && changed_reg;
            out_data_reg.alarm_state   <= prev_flags_reg[6:3];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/plews_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// plews_checker
// Port-level checks of the logger core, bound to the core module.
// ----------------------------------------------------------------------------
module plews_checker
(
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             in_valid,
    input wire logic                             in_ready,
    input wire plews_pkg::in_item_t              in_data,
    input wire logic                             out_valid,
    input wire logic                             out_ready,
    input wire plews_pkg::out_item_t             out_data,
    input wire logic                             cfg_valid,
    input wire logic                             cfg_ready,
    input wire logic [plews_pkg::CFG_IDX_W-1:0]  cfg_index,
    input wire logic [plews_pkg::CFG_DATA_W-1:0] cfg_data
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // one request at a time
    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while busy");

    // only queries emit more than one result
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.result_kind != plews_pkg::KIND_QUERY) |-> out_data.last)
        else $error("non-query result without last");

    // a new alarm shows in the alarm state
    a_alarm_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.new_alarm |-> (out_data.alarm_state != 4'd0)
            && (out_data.result_kind == plews_pkg::KIND_SAMPLE))
        else $error("new alarm without alarm state");

    // charge closes a query
    a_charge_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.result_kind == plews_pkg::KIND_QUERY)
            && (out_data.stat_index == plews_pkg::STAT_CHARGE) |-> out_data.last)
        else $error("charge result not last");

endmodule

bind power_logger_energy_window_stats_core plews_checker u_plews_checker (.*);
`default_nettype wire

// ===== verif/tb_power_logger_energy_window_stats_core.sv =====
// ----------------------------------------------------------------------------
// tb_power_logger_energy_window_stats_core
// Self-checking bench for the power logger core. A clocked driver feeds
// requests from a queue and a clocked monitor predicts every result at the
// input transfer, then checks each output transfer against the oldest
// prediction. Phases vary the register settings and the idling on both sides.
// ----------------------------------------------------------------------------
module tb_power_logger_energy_window_stats_core;

    localparam int DEPTH = plews_pkg::SAMPLE_DEPTH;

    logic                             clk;
    logic                             rst_n;
    logic                             in_valid;
    logic                             in_ready;
    plews_pkg::in_item_t              in_data;
    logic                             out_valid;
    logic                             out_ready;
    plews_pkg::out_item_t             out_data;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [plews_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [plews_pkg::CFG_DATA_W-1:0] cfg_data;

    power_logger_energy_window_stats_core dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // pending requests and predicted results
    plews_pkg::in_item_t  req_queue[$];
    plews_pkg::out_item_t result_queue[$];
    int        fail_count;
    int        idle_pct;
    int        stall_pct;
    bit        run_done;
    bit        in_took;

    // shadow state of the logger
    bit [19:0] sh_max_gap;
    bit [19:0] sh_min_mean;
    bit [31:0] rec_time[DEPTH];
    bit [19:0] rec_v[DEPTH];
    bit [19:0] rec_i[DEPTH];
    bit [23:0] rec_p[DEPTH];
    bit [63:0] rec_energy[DEPTH];
    int        wr_ptr;
    int        fill;
    bit [63:0] energy_sum;
    bit [63:0] energy_origin;
    bit [31:0] last_time;
    bit [23:0] last_power;
    bit        seen_sample;
    bit [6:0]  last_flags;

    // stimulus generator state
    bit [31:0] gen_t;
    int        gen_gap;

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // drop the session contents, keep the flag history
    function automatic void wipe_session();
        for (int n = 0; n < DEPTH; n++)
        begin
            rec_time[n] = '0;
        end
        wr_ptr        = 0;
        fill          = 0;
        energy_sum    = '0;
        energy_origin = '0;
        last_time     = '0;
        last_power    = '0;
        seen_sample   = 1'b0;
    endfunction

    function automatic plews_pkg::out_item_t make_result(bit [1:0] kind, bit [3:0] idx,
                                                         bit [63:0] val, bit fin,
                                                         bit [3:0] alarm);
        plews_pkg::out_item_t r;
        r               = '0;
        r.result_kind   = kind;
        r.stat_index    = idx;
        r.value         = val;
        r.last          = fin;
        r.alarm_state   = alarm;
        return r;
    endfunction

    // work out the results of one accepted request
    function automatic void predict_logger(plews_pkg::in_item_t it);
        bit [3:0]  held_alarm;
        bit [6:0]  flags;
        bit [31:0] dt;
        bit [63:0] inc;
        bit [63:0] sum[3];
        bit [63:0] peak[3];
        bit [63:0] low[3];
        bit [63:0] mean[3];
        bit [63:0] x[3];
        bit [63:0] e_first;
        bit [63:0] e_last;
        bit [63:0] delta;
        bit [63:0] charge;
        bit [63:0] q;
        bit [63:0] r;
        bit [31:0] lo;
        bit [31:0] hi;
        int        count;
        int        pos;
        int        idx;
        plews_pkg::out_item_t res;
        held_alarm = last_flags[6:3];
        case (it.req_type)
            plews_pkg::REQ_SAMPLE:
            begin
                flags = {it.alarm_flags, it.mode_flags};
                res = make_result(plews_pkg::KIND_SAMPLE, plews_pkg::STAT_COUNT, '0, 1'b1,
                                  it.alarm_flags);
                res.flags_changed = (flags != last_flags);
                res.new_alarm     = |(it.alarm_flags & ~held_alarm);
                last_flags = flags;
                if (seen_sample && it.time_ms > last_time)
                begin
                    dt = it.time_ms - last_time;
                    if (dt < sh_max_gap)
                    begin
                        inc = (64'(it.power_mw) + 64'(last_power)) * 64'(dt);
                        energy_sum = (energy_sum > ~inc) ? '1 : energy_sum + inc;
                    end
                end
                seen_sample = 1'b1;
                last_time   = it.time_ms;
                last_power  = it.power_mw;
                rec_time[wr_ptr]   = it.time_ms;
                rec_v[wr_ptr]      = it.voltage_mv;
                rec_i[wr_ptr]      = it.current_ma;
                rec_p[wr_ptr]      = it.power_mw;
                rec_energy[wr_ptr] = energy_sum;
                wr_ptr = (wr_ptr + 1) % DEPTH;
                if (fill < DEPTH)
                begin
                    fill++;
                end
                res.value = (energy_sum >= energy_origin) ? energy_sum - energy_origin : '0;
                result_queue.push_back(res);
            end
            plews_pkg::REQ_RESET:
            begin
                energy_origin = energy_sum;
                result_queue.push_back(make_result(plews_pkg::KIND_RESET,
                                                   plews_pkg::STAT_COUNT, '0, 1'b1,
                                                   held_alarm));
            end
            plews_pkg::REQ_CLEAR:
            begin
                wipe_session();
                result_queue.push_back(make_result(plews_pkg::KIND_CLEAR,
                                                   plews_pkg::STAT_COUNT, '0, 1'b1,
                                                   held_alarm));
            end
            default:
            begin
                lo = (it.range_start_ms < it.range_end_ms) ? it.range_start_ms
                                                           : it.range_end_ms;
                hi = (it.range_start_ms < it.range_end_ms) ? it.range_end_ms
                                                           : it.range_start_ms;
                count   = 0;
                e_first = '0;
                e_last  = '0;
                charge  = '0;
                for (int k = 0; k < 3; k++)
                begin
                    sum[k]  = '0;
                    peak[k] = '0;
                    low[k]  = '0;
                end
                pos = (wr_ptr + DEPTH - fill) % DEPTH;
                // walk the ring from the oldest record
                for (int n = 0; n < fill; n++)
                begin
                    idx = (pos + n) % DEPTH;
                    if (rec_time[idx] >= lo && rec_time[idx] <= hi)
                    begin
                        x[0] = 64'(rec_v[idx]);
                        x[1] = 64'(rec_i[idx]);
                        x[2] = 64'(rec_p[idx]);
                        for (int k = 0; k < 3; k++)
                        begin
                            sum[k] += x[k];
                            if (count == 0 || x[k] > peak[k])
                            begin
                                peak[k] = x[k];
                            end
                            if (count == 0 || x[k] < low[k])
                            begin
                                low[k] = x[k];
                            end
                        end
                        if (count == 0)
                        begin
                            e_first = rec_energy[idx];
                        end
                        e_last = rec_energy[idx];
                        count++;
                    end
                end
                result_queue.push_back(make_result(plews_pkg::KIND_QUERY,
                                                   plews_pkg::STAT_COUNT, 64'(count), 1'b0,
                                                   held_alarm));
                result_queue.push_back(make_result(plews_pkg::KIND_QUERY,
                                                   plews_pkg::STAT_DUR, 64'(hi - lo),
                                                   count == 0, held_alarm));
                if (count != 0)
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        mean[k] = sum[k] / 64'(count);
                    end
                    delta = (e_last >= e_first) ? e_last - e_first : '0;
                    // charge only above the voltage gate
                    if (mean[0] > 64'(sh_min_mean) && mean[0] != 0)
                    begin
                        q = delta / mean[0];
                        r = delta % mean[0];
                        if (q > (64'hFFFF_FFFF_FFFF_FFFF - 64'd1000) / 64'd1000)
                        begin
                            charge = '1;
                        end
                        else
                        begin
                            charge = q * 64'd1000 + (r * 64'd1000) / mean[0];
                        end
                    end
                    for (int k = 0; k < 3; k++)
                    begin
                        result_queue.push_back(make_result(plews_pkg::KIND_QUERY,
                                                           plews_pkg::STAT_MEAN_V + 4'(k),
                                                           mean[k], 1'b0, held_alarm));
                    end
                    for (int k = 0; k < 3; k++)
                    begin
                        result_queue.push_back(make_result(plews_pkg::KIND_QUERY,
                                                           plews_pkg::STAT_PEAK_V + 4'(k),
                                                           peak[k], 1'b0, held_alarm));
                    end
                    for (int k = 0; k < 3; k++)
                    begin
                        result_queue.push_back(make_result(plews_pkg::KIND_QUERY,
                                                           plews_pkg::STAT_MIN_V + 4'(k),
                                                           low[k], 1'b0, held_alarm));
                    end
                    result_queue.push_back(make_result(plews_pkg::KIND_QUERY,
                                                       plews_pkg::STAT_ENERGY, delta, 1'b0,
                                                       held_alarm));
                    result_queue.push_back(make_result(plews_pkg::KIND_QUERY,
                                                       plews_pkg::STAT_CHARGE, charge, 1'b1,
                                                       held_alarm));
                end
            end
        endcase
    endfunction

    // monitor: predict on input transfers, check on output transfers
    always @(posedge clk)
    begin
        plews_pkg::out_item_t want;
        in_took = 1'b0;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == plews_pkg::CFG_MAX_GAP)
                begin
                    sh_max_gap = cfg_data[19:0];
                end
                else if (cfg_index == plews_pkg::CFG_MIN_MEAN)
                begin
                    sh_min_mean = cfg_data[19:0];
                end
            end
            if (in_valid && in_ready)
            begin
                in_took = 1'b1;
                predict_logger(in_data);
            end
            if (out_valid && out_ready)
            begin
                if (result_queue.size() == 0)
                begin
                    $error("unexpected result transfer: %p", out_data);
                    fail_count++;
                end
                else
                begin
                    want = result_queue.pop_front();
                    if (out_data.result_kind !== want.result_kind)
                    begin
                        $error("result_kind: expected %0d, got %0d", want.result_kind,
                               out_data.result_kind);
                        fail_count++;
                    end
                    if (out_data.stat_index !== want.stat_index)
                    begin
                        $error("stat_index: expected %0d, got %0d", want.stat_index,
                               out_data.stat_index);
                        fail_count++;
                    end
                    if (out_data.value !== want.value)
                    begin
                        $error("value: expected %0d, got %0d", want.value, out_data.value);
                        fail_count++;
                    end
                    if (out_data.last !== want.last)
                    begin
                        $error("last: expected %0b, got %0b", want.last, out_data.last);
                        fail_count++;
                    end
                    if (out_data.new_alarm !== want.new_alarm)
                    begin
                        $error("new_alarm: expected %0b, got %0b", want.new_alarm,
                               out_data.new_alarm);
                        fail_count++;
                    end
                    if (out_data.flags_changed !== want.flags_changed)
                    begin
                        $error("flags_changed: expected %0b, got %0b", want.flags_changed,
                               out_data.flags_changed);
                        fail_count++;
                    end
                    if (out_data.alarm_state !== want.alarm_state)
                    begin
                        $error("alarm_state: expected %0h, got %0h", want.alarm_state,
                               out_data.alarm_state);
                        fail_count++;
                    end
                end
            end
        end
    end

    // driver: hold an untaken request, else issue the next one or idle
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_took)
            begin
                if (req_queue.size() != 0 && $urandom_range(0, 99) >= idle_pct)
                begin
                    in_data  <= req_queue.pop_front();
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
            out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    function automatic plews_pkg::in_item_t sample_req(bit [31:0] t, bit [19:0] v,
                                                       bit [19:0] c, bit [23:0] p,
                                                       bit [2:0] mode, bit [3:0] alarm);
        plews_pkg::in_item_t it;
        it             = '0;
        it.req_type    = plews_pkg::REQ_SAMPLE;
        it.time_ms     = t;
        it.voltage_mv  = v;
        it.current_ma  = c;
        it.power_mw    = p;
        it.mode_flags  = mode;
        it.alarm_flags = alarm;
        return it;
    endfunction

    function automatic plews_pkg::in_item_t plain_req(bit [1:0] kind, bit [31:0] a,
                                                      bit [31:0] b);
        plews_pkg::in_item_t it;
        it                = '0;
        it.req_type       = kind;
        it.range_start_ms = a;
        it.range_end_ms   = b;
        return it;
    endfunction

    function automatic plews_pkg::in_item_t random_sample();
        int        pick;
        bit [19:0] v;
        bit [19:0] c;
        bit [23:0] p;
        pick = $urandom_range(0, 19);
        if (pick == 0)
        begin
            gen_t = gen_t - $urandom_range(0, 200);
        end
        else if (pick == 1)
        begin
            gen_t = gen_t + gen_gap + $urandom_range(0, 3000);
        end
        else if (pick == 2)
        begin
            gen_t = $urandom;
        end
        else
        begin
            gen_t = gen_t + $urandom_range(1, (gen_gap > 4000) ? 4000 : gen_gap);
        end
        if ($urandom_range(0, 3) == 0)
        begin
            v = $urandom;
            c = $urandom;
            p = $urandom;
        end
        else
        begin
            v = $urandom_range(0, 30000);
            c = $urandom_range(0, 5000);
            p = $urandom_range(0, 150000);
        end
        return sample_req(gen_t, v, c, p, $urandom_range(0, 7), $urandom_range(0, 15));
    endfunction

    function automatic plews_pkg::in_item_t random_request();
        int        pick;
        bit [31:0] a;
        bit [31:0] b;
        pick = $urandom_range(0, 99);
        if (pick < 72)
        begin
            return random_sample();
        end
        if (pick < 78)
        begin
            return plain_req(plews_pkg::REQ_RESET, $urandom, $urandom);
        end
        if (pick < 81)
        begin
            return plain_req(plews_pkg::REQ_CLEAR, $urandom, $urandom);
        end
        // range query: near the recent samples, empty, or anywhere
        pick = $urandom_range(0, 9);
        if (pick < 6)
        begin
            a = gen_t - $urandom_range(0, 60000);
            b = gen_t + $urandom_range(0, 10);
        end
        else if (pick < 8)
        begin
            a = gen_t + $urandom_range(1, 1000);
            b = a + $urandom_range(0, 1000);
        end
        else
        begin
            a = $urandom;
            b = $urandom;
        end
        return ($urandom_range(0, 1) != 0) ? plain_req(plews_pkg::REQ_QUERY, a, b)
                                           : plain_req(plews_pkg::REQ_QUERY, b, a);
    endfunction

    // hold off until every request is taken and every result checked
    task automatic drain();
        while (req_queue.size() != 0 || in_valid || result_queue.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic [plews_pkg::CFG_IDX_W-1:0] idx,
                             logic [plews_pkg::CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(int n, int gap, int mean_gate, int ip, int sp);
        drain();
        write_reg(plews_pkg::CFG_MAX_GAP, gap);
        write_reg(plews_pkg::CFG_MIN_MEAN, mean_gate);
        gen_gap   = gap;
        idle_pct  = ip;
        stall_pct = sp;
        for (int k = 0; k < n; k++)
        begin
            req_queue.push_back(random_request());
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        out_ready  = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        idle_pct   = 0;
        stall_pct  = 0;
        fail_count = 0;
        sh_max_gap  = 20'd10000;
        sh_min_mean = 20'd10;
        last_flags  = '0;
        wipe_session();
        gen_t   = 32'd1000;
        gen_gap = 10000;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty store, extremes, ordering and gap cases, flags
        req_queue.push_back(plain_req(plews_pkg::REQ_QUERY, 32'd0, 32'hFFFF_FFFF));
        req_queue.push_back(sample_req(32'd0, 20'd0, 20'd0, 24'd0, 3'd0, 4'd0));
        req_queue.push_back(sample_req(32'd100, 20'hFFFFF, 20'hFFFFF, 24'hFFFFFF,
                                       3'd7, 4'd15));
        req_queue.push_back(sample_req(32'd100, 20'd5000, 20'd100, 24'd500, 3'd7, 4'd15));
        req_queue.push_back(sample_req(32'd50, 20'd5000, 20'd100, 24'd500, 3'd2, 4'd0));
        req_queue.push_back(sample_req(32'd10050, 20'd5000, 20'd100, 24'd500, 3'd2, 4'd1));
        req_queue.push_back(sample_req(32'd20049, 20'd12000, 20'd300, 24'd3600, 3'd2, 4'd3));
        req_queue.push_back(plain_req(plews_pkg::REQ_QUERY, 32'd20049, 32'd0));
        req_queue.push_back(plain_req(plews_pkg::REQ_QUERY, 32'd100, 32'd100));
        req_queue.push_back(plain_req(plews_pkg::REQ_QUERY, 32'd20050, 32'hFFFF_FFFF));
        req_queue.push_back(plain_req(plews_pkg::REQ_RESET, 32'd0, 32'd0));
        req_queue.push_back(sample_req(32'd20100, 20'd12000, 20'd300, 24'd3600, 3'd6, 4'd8));
        req_queue.push_back(plain_req(plews_pkg::REQ_QUERY, 32'd0, 32'hFFFF_FFFF));
        req_queue.push_back(plain_req(plews_pkg::REQ_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        req_queue.push_back(plain_req(plews_pkg::REQ_QUERY, 32'd0, 32'hFFFF_FFFF));
        req_queue.push_back(sample_req(32'hFFFF_FFF0, 20'd3, 20'd1, 24'd2, 3'd5, 4'd8));
        req_queue.push_back(sample_req(32'hFFFF_FFFF, 20'd3, 20'd1, 24'd2, 3'd5, 4'd8));
        req_queue.push_back(plain_req(plews_pkg::REQ_QUERY, 32'hFFFF_FFFF, 32'hFFFF_FFF0));
        req_queue.push_back(sample_req(32'h7FFF_FFFF, 20'd9, 20'd1, 24'd2, 3'd0, 4'd0));
        req_queue.push_back(plain_req(plews_pkg::REQ_QUERY, 32'hFFFF_FFFF, 32'd0));

        // random phases over several register settings and idling mixes
        random_phase(110, 1, 0, 0, 0);
        random_phase(110, 600000, 1048575, 76, 0);
        random_phase(110, 5000, 1000, 0, 76);
        random_phase(110, 20000, 0, 38, 38);

        // close with a query over everything still held
        drain();
        idle_pct  = 0;
        stall_pct = 0;
        req_queue.push_back(plain_req(plews_pkg::REQ_QUERY, 32'd0, 32'hFFFF_FFFF));

        drain();
        repeat (40) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

    // watchdog
    initial
    begin
        #40000000;
        $display("FAILURE");
        $finish;
    end

endmodule
